// ===== src/bitmap_frame_allocator_assert.svh =====
// assertion macros used by the frame allocator top level
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame allocator assertion failed");

// next-cycle implication
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame allocator assertion failed");

`endif

// ===== src/bfa_pkg.sv =====
// shared widths, operation codes and status codes of the frame allocator
package bfa_pkg;

   localparam int unsigned WORD_W   = 32;
   localparam int unsigned BIT_W    = 5;
   localparam int unsigned FUNC_W   = 2;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FRAME_W  = 20;
   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned INDEX_W  = 18;
   localparam int unsigned FADDR_W  = 30;
   localparam int unsigned COUNT_W  = 19;

   typedef enum logic [FUNC_W-1:0] {
      OP_ALLOC     = 2'd0,
      OP_FREE      = 2'd1,
      OP_MARK_USED = 2'd2,
      OP_MARK_FREE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_NOMEM = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

endpackage

// ===== src/bitmap_frame_allocator.sv =====
// first-fit bitmap frame allocator top level
//
// Commands enter on start with req_func, req_frame and req_address and are
// taken when busy is low. Each command gives one result on the rsp_ ports,
// shown for exactly one cycle with rsp_valid high; the receiver cannot stall.
// csr_installed_frames sets the installed frame count used for rsp_used_count;
// csr_ready is always high; the register is to be written only while idle,
// which the block itself does not enforce. A mark reads its bitmap word and
// writes it back if the bit changes; a free by address first divides, by a
// shift for a power-of-two frame size, else by a two-stage reciprocal
// multiply, then goes on as a mark; an out-of-range frame skips the bitmap
// access. Allocate reads the bitmap words from the lowest word that may hold
// a free frame, one word per cycle through the memory read port; out of
// memory that is known before the scan is reported without one.
// One command is in flight at a time; the next may start in the cycle that
// shows the result. After reset the block stays busy while every bitmap
// word is written to all ones; every frame starts used, the free count and
// the installed frame register start at zero.
`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator #(
   parameter int NUM_FRAMES  = 262144,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [bfa_pkg::FUNC_W-1:0]   req_func,
   input  logic [bfa_pkg::FRAME_W-1:0]  req_frame,
   input  logic [bfa_pkg::ADDR_W-1:0]   req_address,
   output logic                         rsp_valid,
   output logic [bfa_pkg::STATUS_W-1:0] rsp_status,
   output logic [bfa_pkg::INDEX_W-1:0]  rsp_frame_index,
   output logic [bfa_pkg::FADDR_W-1:0]  rsp_frame_address,
   output logic [bfa_pkg::COUNT_W-1:0]  rsp_free_count,
   output logic [bfa_pkg::COUNT_W-1:0]  rsp_used_count,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bfa_pkg::COUNT_W-1:0]  csr_installed_frames
);
   import bfa_pkg::*;

   localparam int MAP_WORDS = (NUM_FRAMES + 31) / 32;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int TW        = AW + BIT_W;
   localparam int HW        = $clog2(MAP_WORDS + 1);
   localparam int CW        = $clog2(NUM_FRAMES + 1);
   localparam int UW        = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int PW        = TW + 17;
   localparam logic [FRAME_W:0]  FRAME_LIMIT = (FRAME_W + 1)'(NUM_FRAMES);
   localparam logic [ADDR_W-1:0] QUOT_LIMIT  = ADDR_W'(NUM_FRAMES);
   localparam logic [AW-1:0]     LAST_WORD   = AW'(MAP_WORDS - 1);
   localparam logic [HW-1:0]     NO_HINT     = HW'(MAP_WORDS);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_DIV   = 6'b000100,
      S_RMW   = 6'b001000,
      S_SCAN  = 6'b010000,
      S_FIN   = 6'b100000
   } state_type;

   function automatic logic [BIT_W-1:0] low_zero(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (!w[i]) begin
            r = BIT_W'(i);
         end
      end
      return r;
   endfunction

   state_type          state_ff, state_in;
   op_type             func_ff, func_in;
   status_type         status_ff, status_in;
   logic [TW-1:0]      tgt_ff, tgt_in;
   logic [TW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      scan_ff, scan_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [HW-1:0]      hint_ff, hint_in;
   logic [CW-1:0]      free_ff, free_in;
   logic [COUNT_W-1:0] total_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [FADDR_W-1:0] rsp_addr_ff;
   logic [COUNT_W-1:0] rsp_free_ff;
   logic [COUNT_W-1:0] rsp_used_ff;

   logic               rd_en, wr_en;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [WORD_W-1:0]  rd_data, wr_data;

   logic               div_start, div_done;
   logic [ADDR_W-1:0]  div_quot;

   logic [TW-1:0]      req_tgt, quot_tgt;
   logic [AW-1:0]      tgt_word;
   logic               cur_bit, want_used;
   logic [BIT_W-1:0]   scan_bit;
   logic [PW-1:0]      addr_prod;
   logic [UW-1:0]      total_ext, free_ext;

   bfa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bfa_frame_div #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_address),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_tgt   = TW'(req_frame);
   assign quot_tgt  = TW'(div_quot);
   assign tgt_word  = tgt_ff[TW-1:BIT_W];
   assign cur_bit   = rd_data[tgt_ff[BIT_W-1:0]];
   assign want_used = (func_ff == OP_MARK_USED);
   assign scan_bit  = low_zero(rd_data);
   assign addr_prod = PW'(idx_ff) * PW'(FRAME_BYTES);
   assign total_ext = UW'(total_ff);
   assign free_ext  = UW'(free_ff);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      status_in    = status_ff;
      tgt_in       = tgt_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      clr_in       = clr_ff;
      hint_in      = hint_ff;
      free_in      = free_ff;
      rsp_valid_in = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      div_start    = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            if (clr_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               func_in   = op_type'(req_func);
               status_in = STAT_OK;
               idx_in    = '0;
               case (op_type'(req_func))
                  OP_ALLOC: begin
                     if (free_ff == '0 || hint_ff == NO_HINT) begin
                        status_in = STAT_NOMEM;
                        state_in  = S_FIN;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(hint_ff);
                        scan_in  = AW'(hint_ff);
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
                  default: begin
                     if ({1'b0, req_frame} < FRAME_LIMIT) begin
                        tgt_in   = req_tgt;
                        rd_en    = 1'b1;
                        rd_addr  = req_tgt[TW-1:BIT_W];
                        state_in = S_RMW;
                     end else begin
                        status_in = STAT_RANGE;
                        state_in  = S_FIN;
                     end
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_quot < QUOT_LIMIT) begin
                  tgt_in   = quot_tgt;
                  rd_en    = 1'b1;
                  rd_addr  = quot_tgt[TW-1:BIT_W];
                  state_in = S_RMW;
               end else begin
                  status_in = STAT_RANGE;
                  state_in  = S_FIN;
               end
            end
         end
         S_RMW: begin
            if (cur_bit != want_used) begin
               wr_en   = 1'b1;
               wr_addr = tgt_word;
               wr_data = rd_data;
               wr_data[tgt_ff[BIT_W-1:0]] = want_used;
               if (want_used) begin
                  free_in = free_ff - CW'(1);
               end else begin
                  free_in = free_ff + CW'(1);
                  if (HW'(tgt_word) < hint_ff) begin
                     hint_in = HW'(tgt_word);
                  end
               end
            end
            state_in = S_FIN;
         end
         S_SCAN: begin
            if (rd_data != '1) begin
               wr_en   = 1'b1;
               wr_addr = scan_ff;
               wr_data = rd_data;
               wr_data[scan_bit] = 1'b1;
               idx_in   = {scan_ff, scan_bit};
               free_in  = free_ff - CW'(1);
               hint_in  = HW'(scan_ff);
               state_in = S_FIN;
            end else if (scan_ff == LAST_WORD) begin
               status_in = STAT_NOMEM;
               hint_in   = NO_HINT;
               state_in  = S_FIN;
            end else begin
               scan_in = scan_ff + AW'(1);
               rd_en   = 1'b1;
               rd_addr = scan_ff + AW'(1);
            end
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= NO_HINT;
         free_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            total_ff <= csr_installed_frames;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      status_ff <= status_in;
      tgt_ff    <= tgt_in;
      idx_ff    <= idx_in;
      scan_ff   <= scan_in;
      if (state_ff == S_FIN) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= INDEX_W'(idx_ff);
         rsp_addr_ff   <= FADDR_W'(addr_prod);
         rsp_free_ff   <= COUNT_W'(free_ff);
         rsp_used_ff   <= (total_ext > free_ext) ? COUNT_W'(total_ext - free_ext) : '0;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_free_count    = rsp_free_ff;
   assign rsp_used_count    = rsp_used_ff;

   `BFA_ASSERT_NEXT(a_accept_goes_busy, clock, reset, start && !busy, busy)
   `BFA_ASSERT_NEXT(a_fin_gives_result, clock, reset, state_ff == S_FIN, rsp_valid)
   `BFA_ASSERT_IMPLY(a_fail_has_no_frame, clock, reset,
      rsp_valid && rsp_status != STAT_OK, rsp_frame_index == '0 && rsp_frame_address == '0)
   `BFA_ASSERT_IMPLY(a_free_within_map, clock, reset, state_ff != S_CLEAR,
      free_ff <= CW'(NUM_FRAMES))

endmodule

// ===== src/bfa_map_ram.sv =====
// frame bitmap memory, one write port and one registered read port
module bfa_map_ram #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [bfa_pkg::WORD_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [bfa_pkg::WORD_W-1:0] wr_data
);
   import bfa_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/bfa_frame_div.sv =====
// address to frame number divider, shift for power-of-two frame sizes, reciprocal multiply otherwise
module bfa_frame_div #(
   parameter int FRAME_BYTES = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bfa_pkg::ADDR_W-1:0] dividend,
   output logic                       done,
   output logic [bfa_pkg::ADDR_W-1:0] quotient
);
   import bfa_pkg::*;

   localparam bit IS_POW2 = ((FRAME_BYTES & (FRAME_BYTES - 1)) == 0);
   localparam int SH      = $clog2(FRAME_BYTES);

   generate
      if (IS_POW2) begin : g_shift
         logic              done_ff;
         logic [ADDR_W-1:0] quot_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               quot_ff <= dividend >> SH;
            end
         end

         assign done     = done_ff;
         assign quotient = quot_ff;
      end else begin : g_recip
         localparam int LO_W = 17;
         localparam int HI_W = 16;
         localparam int PW   = ADDR_W + LO_W + HI_W;
         localparam int RS   = ADDR_W + SH;
         localparam logic [63:0] RECIP =
            ((64'd1 << RS) + 64'(FRAME_BYTES) - 64'd1) / 64'(FRAME_BYTES);
         localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
         localparam logic [HI_W-1:0] RECIP_HI = RECIP[LO_W+HI_W-1:LO_W];

         logic                   stage_ff;
         logic                   done_ff;
         logic [ADDR_W+LO_W-1:0] lo_ff;
         logic [ADDR_W+HI_W-1:0] hi_ff;
         logic [ADDR_W-1:0]      quo_ff;
         logic [PW-1:0]          prod;

         // full product, the sum of the partial products of the two halves of the reciprocal
         assign prod = PW'(lo_ff) + (PW'(hi_ff) << LO_W);

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= 1'b0;
               done_ff  <= 1'b0;
            end else begin
               stage_ff <= start;
               done_ff  <= stage_ff;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               lo_ff <= (ADDR_W + LO_W)'(dividend) * (ADDR_W + LO_W)'(RECIP_LO);
               hi_ff <= (ADDR_W + HI_W)'(dividend) * (ADDR_W + HI_W)'(RECIP_HI);
            end
            if (stage_ff) begin
               quo_ff <= ADDR_W'(prod >> RS);
            end
         end

         assign done     = done_ff;
         assign quotient = quo_ff;
      end
   endgenerate

endmodule

// ===== bench/bitmap_frame_allocator_check.sv =====
`timescale 1ns / 1ps
// checker for the frame allocator: tracks the bitmap and compares every result transaction
module bitmap_frame_allocator_check #(
   parameter int NUM_FRAMES  = 262144,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [bfa_pkg::FUNC_W-1:0]   req_func,
   input  logic [bfa_pkg::FRAME_W-1:0]  req_frame,
   input  logic [bfa_pkg::ADDR_W-1:0]   req_address,
   input  logic                         rsp_valid,
   input  logic [bfa_pkg::STATUS_W-1:0] rsp_status,
   input  logic [bfa_pkg::INDEX_W-1:0]  rsp_frame_index,
   input  logic [bfa_pkg::FADDR_W-1:0]  rsp_frame_address,
   input  logic [bfa_pkg::COUNT_W-1:0]  rsp_free_count,
   input  logic [bfa_pkg::COUNT_W-1:0]  rsp_used_count,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [bfa_pkg::COUNT_W-1:0]  csr_installed_frames,
   output int unsigned                  pending_count,
   output int unsigned                  error_count
);
   import bfa_pkg::*;

   localparam int unsigned MAP_WORDS = (NUM_FRAMES + WORD_W - 1) / WORD_W;

   typedef struct packed {
      status_type         status;
      logic [INDEX_W-1:0] frame_index;
      logic [FADDR_W-1:0] frame_address;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] used_count;
   } frame_result_type;

   logic [WORD_W-1:0]  used_words [MAP_WORDS];
   logic [COUNT_W-1:0] free_frames;
   logic [COUNT_W-1:0] installed_frames;
   int unsigned        lowest_open_word;
   frame_result_type   awaited_results [$];

   function automatic status_type set_frame_state(logic [31:0] frame, logic make_used);
      int unsigned w;
      int unsigned b;
      if (frame >= NUM_FRAMES) return STAT_RANGE;
      w = frame >> BIT_W;
      b = frame & (WORD_W - 1);
      if (used_words[w][b] != make_used) begin
         used_words[w][b] = make_used;
         if (make_used) begin
            free_frames = free_frames - 1'b1;
         end else begin
            free_frames = free_frames + 1'b1;
            if (w < lowest_open_word) lowest_open_word = w;
         end
      end
      return STAT_OK;
   endfunction

   function automatic frame_result_type run_command(op_type op, logic [FRAME_W-1:0] frame,
                                                    logic [ADDR_W-1:0] address);
      frame_result_type r;
      int unsigned      w;
      int unsigned      b;
      logic [31:0]      hit;
      logic             found;
      r = '0;
      case (op)
         OP_ALLOC: begin
            r.status = STAT_NOMEM;
            found = 1'b0;
            for (w = lowest_open_word; w < MAP_WORDS && !found; w++) begin
               if (used_words[w] != '1) begin
                  b = 0;
                  while (used_words[w][b]) b++;
                  hit = w * WORD_W + b;
                  if (hit < NUM_FRAMES) begin
                     used_words[w][b] = 1'b1;
                     free_frames = free_frames - 1'b1;
                     r.status = STAT_OK;
                     r.frame_index = INDEX_W'(hit);
                     r.frame_address = FADDR_W'(hit * FRAME_BYTES);
                     lowest_open_word = w;
                     found = 1'b1;
                  end
               end
            end
            if (!found) lowest_open_word = MAP_WORDS;
         end
         OP_FREE:      r.status = set_frame_state(address / FRAME_BYTES, 1'b0);
         OP_MARK_USED: r.status = set_frame_state(32'(frame), 1'b1);
         default:      r.status = set_frame_state(32'(frame), 1'b0);
      endcase
      r.free_count = free_frames;
      r.used_count = (installed_frames > free_frames) ? installed_frames - free_frames : '0;
      return r;
   endfunction

   task automatic check_result(frame_result_type want);
      if (rsp_status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, rsp_status);
         error_count++;
      end
      if (rsp_frame_index !== want.frame_index) begin
         $error("frame_index: expected %0d, actual %0d", want.frame_index, rsp_frame_index);
         error_count++;
      end
      if (rsp_frame_address !== want.frame_address) begin
         $error("frame_address: expected %0h, actual %0h", want.frame_address,
                rsp_frame_address);
         error_count++;
      end
      if (rsp_free_count !== want.free_count) begin
         $error("free_count: expected %0d, actual %0d", want.free_count, rsp_free_count);
         error_count++;
      end
      if (rsp_used_count !== want.used_count) begin
         $error("used_count: expected %0d, actual %0d", want.used_count, rsp_used_count);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAP_WORDS; i++) used_words[i] = '1;
         free_frames = '0;
         installed_frames = '0;
         lowest_open_word = MAP_WORDS;
         awaited_results.delete();
         error_count = 0;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (awaited_results.size() == 0) begin
               $error("result transaction with no command outstanding");
               error_count++;
            end else begin
               check_result(awaited_results.pop_front());
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) installed_frames = csr_installed_frames;
         if (start === 1'b1 && busy === 1'b0)
            awaited_results.push_back(run_command(op_type'(req_func), req_frame, req_address));
      end
      pending_count = awaited_results.size();
   end

endmodule

// ===== bench/bitmap_frame_allocator_test.sv =====
`timescale 1ns / 1ps
// stimulus and verdict for the first-fit bitmap frame allocator
module bitmap_frame_allocator_test;
   import bfa_pkg::*;

   localparam int NUM_FRAMES  = 262144;
   localparam int FRAME_BYTES = 4096;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 265;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func = '0;
   logic [FRAME_W-1:0]    req_frame = '0;
   logic [ADDR_W-1:0]     req_address = '0;
   logic                  rsp_valid;
   logic [STATUS_W-1:0]   rsp_status;
   logic [INDEX_W-1:0]    rsp_frame_index;
   logic [FADDR_W-1:0]    rsp_frame_address;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic [COUNT_W-1:0]    rsp_used_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_installed_frames = '0;
   int unsigned           pending_count;
   int unsigned           error_count;
   logic                  pauses_on = 1'b1;

   always #10 clock = ~clock;

   bitmap_frame_allocator #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) i_dut (.*);

   bitmap_frame_allocator_check #(
      .NUM_FRAMES  (NUM_FRAMES),
      .FRAME_BYTES (FRAME_BYTES)
   ) i_check (.*);

   task automatic issue(op_type op, logic [FRAME_W-1:0] frame, logic [ADDR_W-1:0] address);
      req_func <= op;
      req_frame <= frame;
      req_address <= address;
      start <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (pauses_on && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_total(logic [COUNT_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_installed_frames <= value;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_command(int unsigned pool);
      int unsigned        roll;
      logic [FRAME_W-1:0] frame;
      roll = $urandom_range(0, 99);
      frame = FRAME_W'($urandom_range(0, pool - 1));
      if (roll < 35)
         issue(OP_ALLOC, FRAME_W'($urandom), $urandom);
      else if (roll < 60)
         issue(OP_MARK_FREE, frame, $urandom);
      else if (roll < 72)
         issue(OP_MARK_USED, frame, $urandom);
      else if (roll < 87)
         issue(OP_FREE, FRAME_W'($urandom),
               frame * FRAME_BYTES + $urandom_range(0, FRAME_BYTES - 1));
      else if (roll < 91)
         issue(roll[0] ? OP_MARK_USED : OP_MARK_FREE, FRAME_W'($urandom_range(0, 20'hFFFFF)),
               $urandom);
      else if (roll < 95)
         issue(OP_FREE, FRAME_W'($urandom), $urandom);
      else if (roll < 96)
         issue(OP_MARK_FREE, FRAME_W'($urandom_range(NUM_FRAMES - 64, NUM_FRAMES - 1)),
               $urandom);
      else
         issue(OP_MARK_USED, FRAME_W'($urandom_range(0, NUM_FRAMES - 1)), $urandom);
   endtask

   initial begin
      int unsigned        pool_sizes [PHASES];
      logic [COUNT_W-1:0] totals [PHASES];
      pool_sizes[0] = 64;
      pool_sizes[1] = 512;
      pool_sizes[2] = 2048;
      pool_sizes[3] = 256;
      pool_sizes[4] = 96;
      totals[0] = '0;
      totals[1] = COUNT_W'(NUM_FRAMES);
      totals[2] = COUNT_W'(1000);
      totals[3] = COUNT_W'($urandom_range(0, NUM_FRAMES));
      totals[4] = COUNT_W'(24);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      write_total(COUNT_W'(NUM_FRAMES));

      // everything starts used, so the first allocate runs out of memory
      issue(OP_ALLOC, '0, '0);
      issue(OP_MARK_FREE, '0, '0);
      issue(OP_MARK_FREE, '0, '0);
      issue(OP_MARK_FREE, FRAME_W'(NUM_FRAMES - 1), '1);
      issue(OP_MARK_FREE, FRAME_W'(NUM_FRAMES), '0);
      issue(OP_MARK_USED, 20'hFFFFF, '0);
      issue(OP_ALLOC, '1, '1);
      issue(OP_ALLOC, '0, '0);
      issue(OP_ALLOC, '0, '0);
      issue(OP_FREE, '0, 32'hFFFF_FFFF);
      issue(OP_FREE, '1, 32'h0000_0000);
      issue(OP_FREE, '0, 32'h3FFF_FFFF);
      issue(OP_FREE, '0, 32'h4000_0000);
      issue(OP_MARK_USED, FRAME_W'(NUM_FRAMES - 1), '0);
      issue(OP_MARK_USED, FRAME_W'(NUM_FRAMES - 1), '0);
      issue(OP_MARK_FREE, FRAME_W'(31), '0);
      issue(OP_MARK_FREE, FRAME_W'(32), '0);
      issue(OP_ALLOC, '0, '0);
      issue(OP_ALLOC, '0, '0);
      issue(OP_ALLOC, '0, '0);
      issue(OP_ALLOC, '0, '0);
      issue(OP_FREE, '0, 33 * FRAME_BYTES + FRAME_BYTES - 1);
      issue(OP_MARK_USED, FRAME_W'(33), '0);

      for (int p = 0; p < PHASES; p++) begin
         write_total(totals[p]);
         pauses_on = (p != PHASES - 1);
         repeat (PHASE_ITEMS) random_command(pool_sizes[p]);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      @(negedge clock);
      if (error_count == 0)
         $display("bitmap_frame_allocator_test: clean");
      else
         $display("bitmap_frame_allocator_test: errors");
      $finish;
   end

   initial begin
      repeat (4) #1000000000;
      $display("bitmap_frame_allocator_test: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/bfa_pkg.sv
src/bfa_map_ram.sv
src/bfa_frame_div.sv
src/bitmap_frame_allocator.sv
bench/bitmap_frame_allocator_check.sv
bench/bitmap_frame_allocator_test.sv
